// ===== rtl/vfdc_pkg.sv =====
// ============================================================================
// vfdc_pkg
// Shared types, constants and reset values of the drive command controller.
// ============================================================================
`default_nettype none

package vfdc_pkg;

  // Default widths of the fixed-point pot path.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;

  // Fixed field widths.
  localparam int FREQ_W     = 9;
  localparam int DB_W       = 12;
  localparam int ALPHA_W    = 9;
  localparam int DEB_W      = 4;
  localparam int RAMP_W     = 8;
  localparam int AMP_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_W      = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LOCK = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_RAMP = 3'd7;

  // Register reset values.
  localparam logic [FREQ_W-1:0]  MIN_FREQ_RST = 9'd10;
  localparam logic [FREQ_W-1:0]  MAX_FREQ_RST = 9'd60;
  localparam logic [DB_W-1:0]    DEADBAND_RST = 12'd410;
  localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd51;
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 4'd3;
  localparam logic [RAMP_W-1:0]  RAMP_RST     = 8'd5;

  // Arithmetic constants.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 9'd256;
  localparam int                 ALPHA_SHIFT  = 8;
  localparam logic [FREQ_W-1:0]  RECIP3       = 9'd342;  // ceil(2^10 / 3)
  localparam int                 RECIP3_SHIFT = 10;
  localparam logic [AMP_W-1:0]   AMP_LOW      = 10'd600;
  localparam logic [AMP_W-1:0]   AMP_HIGH     = 10'd1000;
  localparam logic [RAMP_W-1:0]  RAMP_SAT     = 8'd255;
  localparam int                 DIV_STEPS    = 9;       // one per request bit

  typedef enum logic [1:0] {
    DRV_OFF = 2'd0,
    DRV_FWD = 2'd1,
    DRV_REV = 2'd2
  } drive_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_MAP,
    S_LOAD,
    S_DIV,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic filter;
    logic map;
    logic load;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic out_ready;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/vfdc_ctrl.sv =====
// ============================================================================
// vfdc_ctrl
// Sequencer that steps one tick through filter, map, divide and commit.
// ============================================================================
`default_nettype none

module vfdc_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  output vfdc_pkg::dp_cmd_t         cmd,
  input  wire vfdc_pkg::dp_status_t status
);

  localparam int CNT_W = $clog2(vfdc_pkg::DIV_STEPS + 1);

  vfdc_pkg::ctrl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  can_commit;

  assign can_commit = !status.out_valid || status.out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfdc_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      vfdc_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = vfdc_pkg::S_FILT;
      end
      vfdc_pkg::S_FILT: state_nxt = vfdc_pkg::S_MAP;
      vfdc_pkg::S_MAP:  state_nxt = vfdc_pkg::S_LOAD;
      vfdc_pkg::S_LOAD: begin
        state_nxt = vfdc_pkg::S_DIV;
        cnt_nxt   = '0;
      end
      vfdc_pkg::S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(vfdc_pkg::DIV_STEPS - 1)) state_nxt = vfdc_pkg::S_FIN;
      end
      vfdc_pkg::S_FIN: begin
        if (can_commit) state_nxt = vfdc_pkg::S_IDLE;
      end
      default: state_nxt = vfdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      vfdc_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      vfdc_pkg::S_FILT: cmd.filter   = 1'b1;
      vfdc_pkg::S_MAP:  cmd.map      = 1'b1;
      vfdc_pkg::S_LOAD: cmd.load     = 1'b1;
      vfdc_pkg::S_DIV:  cmd.div_step = 1'b1;
      vfdc_pkg::S_FIN:  cmd.commit   = can_commit;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/vfdc_datapath.sv =====
// ============================================================================
// vfdc_datapath
// Configuration, filter, frequency map divider, debounce, ramp and result.
// ============================================================================
`default_nettype none

module vfdc_datapath #(
  parameter int SAMPLE_BITS = vfdc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = vfdc_pkg::FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [vfdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [vfdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire  [SAMPLE_BITS-1:0]            pot_sample,
  input  wire                               button_level,
  input  wire  vfdc_pkg::dp_cmd_t           cmd,
  output vfdc_pkg::dp_status_t              status,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [vfdc_pkg::OUT_W-1:0]        out_tdata
);

  localparam int FREQ_W = vfdc_pkg::FREQ_W;
  localparam int FW     = SAMPLE_BITS + FRAC_BITS;
  localparam int DBI_W  = (SAMPLE_BITS + 1 > vfdc_pkg::DB_W) ? SAMPLE_BITS + 1 : vfdc_pkg::DB_W;
  localparam int CW     = DBI_W + FRAC_BITS;
  localparam int PW     = FW + vfdc_pkg::ALPHA_W;
  localparam int SW     = PW + 1;
  localparam int NW     = CW + FREQ_W;
  localparam int DVW    = CW + FREQ_W + 2;
  localparam int ZW     = SAMPLE_BITS + 5;
  localparam int F3W    = 2 * FREQ_W;
  localparam int VW     = FREQ_W + 5;

  // Configuration registers.
  logic [FREQ_W-1:0]                min_r, max_r;
  logic [vfdc_pkg::DB_W-1:0]        db_r;
  logic [vfdc_pkg::ALPHA_W-1:0]     alpha_r;
  logic [vfdc_pkg::DEB_W-1:0]       deb_r;
  logic [vfdc_pkg::RAMP_W-1:0]      ramp_r;
  logic                             skip_lock_r, skip_ramp_r;

  // Tick state.
  logic [FW-1:0]                    filt_r;
  logic                             btn_last_r, btn_stable_r;
  logic [vfdc_pkg::DEB_W-1:0]       btn_cnt_r;
  vfdc_pkg::drive_t                 drive_r, last_dir_r;
  logic                             latch_r;
  logic [FREQ_W-1:0]                wave_r;
  logic [vfdc_pkg::RAMP_W-1:0]      rc_r;

  // Working registers of one tick.
  logic                             btn_r, zero_hit_r;
  logic [PW-1:0]                    prod_a_r, prod_b_r;
  logic [F3W-1:0]                   f3_r;
  logic [vfdc_pkg::AMP_W-1:0]       amp_r;
  logic [NW-1:0]                    prod_r;
  logic [CW-1:0]                    den_r;
  logic                             den_zero_r, above_db_r;
  logic [DVW-1:0]                   rem_r, dsh_r;
  logic [FREQ_W-1:0]                q_r;

  logic [vfdc_pkg::OUT_W-1:0]       out_data_r;
  logic                             out_valid_r;

  // Combinational helpers.
  logic [vfdc_pkg::ALPHA_W-1:0]     alpha_eff, alpha_inv;
  logic [ZW-1:0]                    pot_x20;
  logic [SW-1:0]                    filt_sum;
  logic [VW-1:0]                    amp_raw;
  logic [CW-1:0]                    dbs, full, den, filt_e, num_raw, num;
  logic [FREQ_W-1:0]                span;

  // Commit logic.
  logic                             last_nxt, stable_nxt, press;
  logic [vfdc_pkg::DEB_W-1:0]       cnt_nxt;
  vfdc_pkg::drive_t                 drive_nxt, last_dir_nxt;
  logic                             latch_nxt, run;
  logic [FREQ_W-1:0]                req, wave_nxt;
  logic [vfdc_pkg::RAMP_W-1:0]      rc_inc, rc_nxt;

  assign alpha_eff = (alpha_r > vfdc_pkg::ALPHA_ONE) ? vfdc_pkg::ALPHA_ONE : alpha_r;
  assign alpha_inv = vfdc_pkg::ALPHA_ONE - alpha_eff;
  assign pot_x20   = (ZW'(pot_sample) << 4) + (ZW'(pot_sample) << 2);
  assign filt_sum  = SW'(prod_a_r) + (SW'(prod_b_r) << FRAC_BITS);
  assign amp_raw   = (VW'(wave_r) << 4) + VW'(wave_r) + VW'(f3_r >> vfdc_pkg::RECIP3_SHIFT);

  always_comb begin
    dbs     = CW'(db_r) << FRAC_BITS;
    full    = CW'(1) << FW;
    den     = (full > dbs) ? full - dbs : '0;
    filt_e  = CW'(filt_r);
    num_raw = (filt_e > dbs) ? filt_e - dbs : '0;
    num     = (num_raw > den) ? den : num_raw;
    span    = (max_r > min_r) ? max_r - min_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= vfdc_pkg::MIN_FREQ_RST;
      max_r       <= vfdc_pkg::MAX_FREQ_RST;
      db_r        <= vfdc_pkg::DEADBAND_RST;
      alpha_r     <= vfdc_pkg::ALPHA_RST;
      deb_r       <= vfdc_pkg::DEBOUNCE_RST;
      ramp_r      <= vfdc_pkg::RAMP_RST;
      skip_lock_r <= 1'b0;
      skip_ramp_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vfdc_pkg::CFG_MIN_FREQ:  min_r       <= cfg_wdata[FREQ_W-1:0];
        vfdc_pkg::CFG_MAX_FREQ:  max_r       <= cfg_wdata[FREQ_W-1:0];
        vfdc_pkg::CFG_DEADBAND:  db_r        <= cfg_wdata[vfdc_pkg::DB_W-1:0];
        vfdc_pkg::CFG_ALPHA:     alpha_r     <= cfg_wdata[vfdc_pkg::ALPHA_W-1:0];
        vfdc_pkg::CFG_DEBOUNCE:  deb_r       <= cfg_wdata[vfdc_pkg::DEB_W-1:0];
        vfdc_pkg::CFG_RAMP:      ramp_r      <= cfg_wdata[vfdc_pkg::RAMP_W-1:0];
        vfdc_pkg::CFG_SKIP_LOCK: skip_lock_r <= cfg_wdata[0];
        vfdc_pkg::CFG_SKIP_RAMP: skip_ramp_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Payload pipeline of one tick; held between commands.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      btn_r      <= button_level;
      zero_hit_r <= pot_x20 < (ZW'(1) << SAMPLE_BITS);
      prod_a_r   <= PW'(filt_r) * PW'(alpha_inv);
      prod_b_r   <= PW'(pot_sample) * PW'(alpha_eff);
      f3_r       <= F3W'(wave_r) * F3W'(vfdc_pkg::RECIP3);
    end
    if (cmd.filter) begin
      if (amp_raw < VW'(vfdc_pkg::AMP_LOW))        amp_r <= vfdc_pkg::AMP_LOW;
      else if (amp_raw >= VW'(vfdc_pkg::AMP_HIGH)) amp_r <= vfdc_pkg::AMP_HIGH;
      else                                         amp_r <= amp_raw[vfdc_pkg::AMP_W-1:0];
    end
    if (cmd.map) begin
      prod_r     <= NW'(num) * NW'(span);
      den_r      <= den;
      den_zero_r <= (den == '0);
      above_db_r <= filt_e > dbs;
    end
    if (cmd.load) begin
      // Round half up: quotient of (2*num*span + den) by 2*den.
      rem_r <= (DVW'(prod_r) << 1) + DVW'(den_r);
      dsh_r <= DVW'(den_r) << vfdc_pkg::DIV_STEPS;
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[FREQ_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[FREQ_W-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.commit) begin
      out_data_r <= {latch_nxt, amp_r, wave_nxt, req, drive_nxt, run};
    end
  end

  always_comb begin
    req = den_zero_r ? min_r : min_r + q_r;

    last_nxt   = btn_last_r;
    cnt_nxt    = btn_cnt_r;
    stable_nxt = btn_stable_r;
    press      = 1'b0;
    if (btn_r != btn_last_r) begin
      last_nxt = btn_r;
      cnt_nxt  = '0;
    end else if (btn_cnt_r < deb_r) begin
      cnt_nxt = btn_cnt_r + 1'b1;
    end
    if (cnt_nxt >= deb_r && btn_stable_r != last_nxt) begin
      stable_nxt = last_nxt;
      press      = last_nxt;
    end

    drive_nxt    = drive_r;
    last_dir_nxt = last_dir_r;
    if (press) begin
      if (drive_r != vfdc_pkg::DRV_OFF) begin
        drive_nxt = vfdc_pkg::DRV_OFF;
      end else begin
        drive_nxt    = (last_dir_r == vfdc_pkg::DRV_FWD) ? vfdc_pkg::DRV_REV
                                                         : vfdc_pkg::DRV_FWD;
        last_dir_nxt = drive_nxt;
      end
    end
    latch_nxt = latch_r | zero_hit_r | skip_lock_r;
    if (skip_lock_r) drive_nxt = vfdc_pkg::DRV_FWD;

    run = (drive_nxt != vfdc_pkg::DRV_OFF) && latch_nxt && above_db_r && (req >= min_r);

    rc_inc   = (rc_r < vfdc_pkg::RAMP_SAT) ? rc_r + 1'b1 : rc_r;
    rc_nxt   = rc_inc;
    wave_nxt = wave_r;
    if (run) begin
      if (skip_ramp_r) begin
        wave_nxt = req;
      end else if (rc_inc >= ramp_r && req != wave_r) begin
        wave_nxt = (req > wave_r) ? wave_r + 1'b1 : wave_r - 1'b1;
        rc_nxt   = '0;
      end
    end else begin
      wave_nxt = min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r       <= '0;
      btn_last_r   <= 1'b0;
      btn_stable_r <= 1'b0;
      btn_cnt_r    <= '0;
      drive_r      <= vfdc_pkg::DRV_OFF;
      last_dir_r   <= vfdc_pkg::DRV_REV;
      latch_r      <= 1'b0;
      wave_r       <= vfdc_pkg::MIN_FREQ_RST;
      rc_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.filter) filt_r <= filt_sum[FW+vfdc_pkg::ALPHA_SHIFT-1:vfdc_pkg::ALPHA_SHIFT];
      if (cmd.commit) begin
        btn_last_r   <= last_nxt;
        btn_stable_r <= stable_nxt;
        btn_cnt_r    <= cnt_nxt;
        drive_r      <= drive_nxt;
        last_dir_r   <= last_dir_nxt;
        latch_r      <= latch_nxt;
        wave_r       <= wave_nxt;
        rc_r         <= rc_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign status.out_valid = out_valid_r;
  assign status.out_ready = out_tready;
  assign out_tvalid       = out_valid_r;
  assign out_tdata        = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/vf_drive_command_controller_top.sv =====
// ============================================================================
// vf_drive_command_controller_top
// Volts-per-hertz open-loop drive command controller, one result per tick.
// ============================================================================
// Usage: each beat on the in_ channel is one control tick carrying a raw pot
// sample and the raw button level. The block filters the pot, maps it onto a
// requested frequency, debounces the button into Off / Forward / Off / Reverse,
// ramps the wave frequency and returns exactly one beat on the out_ channel.
// From the edge that accepts the input beat to out_tvalid the tick runs
// through these steps: the beat is captured at that edge, then come filter,
// map, divider load, nine divider steps (one request bit each) and commit.
// The block works on one tick at a time and takes no new beat until it is
// idle again right after the commit; the serial divider of the map sets that.
// in_tready is high only while the sequencer is idle. The result sits in an
// output register, so the next tick is taken while an earlier result still
// waits; if the receiver stalls the commit of the following tick waits until
// that result is taken, and nothing is dropped.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// filter and debounce state, sets the drive Off and the wave frequency to the
// default minimum. Configuration writes must only be issued while no tick is
// in progress.
// ============================================================================
`default_nettype none

module vf_drive_command_controller_top #(
  parameter int SAMPLE_BITS = vfdc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = vfdc_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // Input ticks.
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: pot_sample (SAMPLE_BITS), button_level (1), zero fill.
  input  wire  [((SAMPLE_BITS+8)/8)*8-1:0] in_tdata,
  // Results.
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // Fields from bit 0: run (1), direction (2), requested_frequency (9),
  // wave_frequency (9), voltage_amplitude (10), pot_zeroed (1).
  output logic [vfdc_pkg::OUT_W-1:0]       out_tdata,
  // Configuration writes.
  input  wire                              cfg_we,
  input  wire  [vfdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [vfdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  vfdc_pkg::dp_cmd_t    cmd;
  vfdc_pkg::dp_status_t status;

  // The sequencer issues one command per cycle of a tick but stalls the
  // commit on the datapath's output status, so no pending beat is overwritten.
  vfdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .status    (status)
  );

  vfdc_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .pot_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .button_level (in_tdata[SAMPLE_BITS]),
    .cmd          (cmd),
    .status       (status),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

`ifndef ASSERT_OFF
  // Only one tick is in flight: an accepted beat closes the input side.
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a tick is in progress");

  // The drive state never reports the unused code.
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:1] != 2'd3)
    else $error("direction holds an unused code");

  // The amplitude stays inside its clamp.
  a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[30:21] >= vfdc_pkg::AMP_LOW &&
                   out_tdata[30:21] <= vfdc_pkg::AMP_HIGH)
    else $error("voltage amplitude outside its clamp");

  // Running needs a direction and the pot-zero interlock.
  a_run_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2:1] != 2'd0 && out_tdata[31])
    else $error("run set without direction or interlock");
`endif

endmodule

`default_nettype wire
